@@ design/r2q_pkg.sv @@
package r2q_pkg;

    localparam int ELEM_W = 16;
    localparam int QUAT_W = 16;
    // Off-diagonal sums and differences need one bit more than an element.
    localparam int OP_W   = 17;
    // A clamped radicand is positive and below 2^17 for every input pattern.
    localparam int R_W    = 17;
    localparam int LANES  = 3;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } branch_t;

    // Side data carried along the square root chain.
    typedef struct packed {
        branch_t                 branch;
        logic                    bad;
        logic signed [OP_W-1:0]  oa;
        logic signed [OP_W-1:0]  ob;
        logic signed [OP_W-1:0]  oc;
    } sq_side_t;

    // Side data carried along the divider chain.
    typedef struct packed {
        branch_t                 branch;
        logic                    bad;
        logic [QUAT_W-1:0]       big;
        logic [LANES-1:0]        neg;
        logic [LANES-1:0]        ovf;
    } dv_side_t;

endpackage

@@ design/rotation_matrix_to_quaternion_unit.sv @@
// Rotation matrix to quaternion converter (Shepperd's method), fixed point.
//
// Input channel (s_valid/s_ready) takes the nine rotation elements of a 4x4
// matrix in signed fixed point with FRAC_BITS fraction bits. The result
// channel (m_valid/m_ready) gives the quaternion, the branch that picked the
// largest component and a flag for a radicand that had to be clamped.
//
// The block is a single pipeline: one front stage, a chain of bit-serial
// square root cells (one root bit each, (FRAC_BITS+20)/2 cells), one divider
// set-up stage, sixteen restoring divider cells (one quotient bit each, three
// lanes side by side) and the output register. One item is accepted in every
// cycle while the receiver keeps up.
//
// When the receiver holds m_ready low with an item waiting, the whole chain
// freezes and s_ready falls in the same cycle; nothing is lost and the
// waiting item holds still. Reset clears every stage's valid bit, so the
// block comes out of reset empty and ready.
module rotation_matrix_to_quaternion_unit #(
    parameter int FRAC_BITS = 14
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [r2q_pkg::ELEM_W-1:0] s_elem_0,
    input  logic signed [r2q_pkg::ELEM_W-1:0] s_elem_1,
    input  logic signed [r2q_pkg::ELEM_W-1:0] s_elem_2,
    input  logic signed [r2q_pkg::ELEM_W-1:0] s_elem_4,
    input  logic signed [r2q_pkg::ELEM_W-1:0] s_elem_5,
    input  logic signed [r2q_pkg::ELEM_W-1:0] s_elem_6,
    input  logic signed [r2q_pkg::ELEM_W-1:0] s_elem_8,
    input  logic signed [r2q_pkg::ELEM_W-1:0] s_elem_9,
    input  logic signed [r2q_pkg::ELEM_W-1:0] s_elem_10,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [r2q_pkg::QUAT_W-1:0] m_quat_x,
    output logic signed [r2q_pkg::QUAT_W-1:0] m_quat_y,
    output logic signed [r2q_pkg::QUAT_W-1:0] m_quat_z,
    output logic signed [r2q_pkg::QUAT_W-1:0] m_quat_w,
    output logic [1:0]                        m_branch_taken,
    output logic                              m_bad_input
);
    import r2q_pkg::*;

    localparam int VW_MIN = R_W + FRAC_BITS + 2;
    localparam int QW     = (VW_MIN + 1) / 2;
    localparam int VW     = 2 * QW;
    localparam int NW     = QW + 18;
    localparam int NDIV   = QUAT_W;

    logic adv;

    // Front stage outputs.
    logic           fr_valid;
    logic [R_W-1:0] fr_r;
    sq_side_t       fr_side;

    // Square root chain.
    logic           sq_valid [QW+1];
    logic [QW+1:0]  sq_rem   [QW+1];
    logic [QW-1:0]  sq_root  [QW+1];
    logic [VW-1:0]  sq_val   [QW+1];
    sq_side_t       sq_side  [QW+1];

    // Divider set-up stage.
    logic [QW-1:0]                 d;
    logic [QW-1:0]                 big_raw;
    logic signed [OP_W-1:0]        ops [LANES];
    logic [OP_W-1:0]               mag;
    logic [NW-1:0]                 dvs;
    logic [LANES-1:0][NW-1:0]      num;
    dv_side_t                      su_side;
    logic                          su_valid_reg;
    logic [LANES-1:0][NW-1:0]      su_num_reg;
    logic [NW-1:0]                 su_dvs_reg;
    dv_side_t                      su_side_reg;

    // Divider chain.
    logic                             dv_valid [NDIV+1];
    logic [LANES-1:0][NW-1:0]         dv_rem   [NDIV+1];
    logic [LANES-1:0][QUAT_W-1:0]     dv_q     [NDIV+1];
    logic [NW-1:0]                    dv_dvs   [NDIV+1];
    dv_side_t                         dv_side  [NDIV+1];

    // Output stage.
    logic [LANES-1:0][QUAT_W-1:0] res;
    dv_side_t                     fin;
    logic [QUAT_W-1:0]            qx_next, qy_next, qz_next, qw_next;
    logic                         m_valid_reg;
    logic [QUAT_W-1:0]            qx_reg, qy_reg, qz_reg, qw_reg;
    logic [1:0]                   branch_reg;
    logic                         bad_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    r2q_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_valid),
        .e0        (s_elem_0),
        .e1        (s_elem_1),
        .e2        (s_elem_2),
        .e4        (s_elem_4),
        .e5        (s_elem_5),
        .e6        (s_elem_6),
        .e8        (s_elem_8),
        .e9        (s_elem_9),
        .e10       (s_elem_10),
        .valid_reg (fr_valid),
        .r_reg     (fr_r),
        .side_reg  (fr_side)
    );

    assign sq_valid[0] = fr_valid;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_val[0]   = VW'(fr_r) << (FRAC_BITS + 2);
    assign sq_side[0]  = fr_side;

    for (genvar i = 0; i < QW; i++) begin : g_sqrt
        r2q_sqrt_cell #(
            .QW(QW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .valid_in  (sq_valid[i]),
            .rem_in    (sq_rem[i]),
            .root_in   (sq_root[i]),
            .val_in    (sq_val[i]),
            .side_in   (sq_side[i]),
            .valid_reg (sq_valid[i+1]),
            .rem_reg   (sq_rem[i+1]),
            .root_reg  (sq_root[i+1]),
            .val_reg   (sq_val[i+1]),
            .side_reg  (sq_side[i+1])
        );
    end

    // d is 2s; the largest component s/2 is d/4, since both come from floors
    // of square roots whose arguments differ by a factor of sixteen.
    always_comb begin
        d       = sq_root[QW];
        big_raw = d >> 2;
        dvs     = NW'(d) << 1;
        ops[0]  = sq_side[QW].oa;
        ops[1]  = sq_side[QW].ob;
        ops[2]  = sq_side[QW].oc;
        su_side.branch = sq_side[QW].branch;
        su_side.bad    = sq_side[QW].bad;
        su_side.big    = (big_raw > QW'(16'h7fff)) ? 16'h7fff : QUAT_W'(big_raw);
        mag = '0;
        for (int l = 0; l < LANES; l++) begin
            mag            = ops[l][OP_W-1] ? OP_W'(-ops[l]) : OP_W'(ops[l]);
            // Adding d before dividing by 2d rounds to nearest, ties away.
            num[l]         = (NW'(mag) << (FRAC_BITS + 1)) + NW'(d);
            su_side.neg[l] = ops[l][OP_W-1];
            su_side.ovf[l] = num[l] >= (dvs << NDIV);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            su_valid_reg <= 1'b0;
        end else if (adv) begin
            su_valid_reg <= sq_valid[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            su_num_reg  <= num;
            su_dvs_reg  <= dvs;
            su_side_reg <= su_side;
        end
    end

    assign dv_valid[0] = su_valid_reg;
    assign dv_rem[0]   = su_num_reg;
    assign dv_q[0]     = '0;
    assign dv_dvs[0]   = su_dvs_reg;
    assign dv_side[0]  = su_side_reg;

    for (genvar k = 0; k < NDIV; k++) begin : g_div
        r2q_div_cell #(
            .NW (NW),
            .BIT(NDIV - 1 - k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .valid_in  (dv_valid[k]),
            .rem_in    (dv_rem[k]),
            .q_in      (dv_q[k]),
            .dvs_in    (dv_dvs[k]),
            .side_in   (dv_side[k]),
            .valid_reg (dv_valid[k+1]),
            .rem_reg   (dv_rem[k+1]),
            .q_reg     (dv_q[k+1]),
            .dvs_reg   (dv_dvs[k+1]),
            .side_reg  (dv_side[k+1])
        );
    end

    always_comb begin
        fin = dv_side[NDIV];
        for (int l = 0; l < LANES; l++) begin
            if (fin.neg[l]) begin
                res[l] = (fin.ovf[l] || dv_q[NDIV][l] > 16'h8000) ? 16'h8000
                                                                 : 16'h0 - dv_q[NDIV][l];
            end else begin
                res[l] = (fin.ovf[l] || dv_q[NDIV][l][QUAT_W-1]) ? 16'h7fff
                                                                 : dv_q[NDIV][l];
            end
        end
        case (fin.branch)
            BR_TRACE: begin
                qx_next = res[0];
                qy_next = res[1];
                qz_next = res[2];
                qw_next = fin.big;
            end
            BR_X: begin
                qx_next = fin.big;
                qy_next = res[0];
                qz_next = res[1];
                qw_next = res[2];
            end
            BR_Y: begin
                qx_next = res[0];
                qy_next = fin.big;
                qz_next = res[1];
                qw_next = res[2];
            end
            default: begin
                qx_next = res[0];
                qy_next = res[1];
                qz_next = fin.big;
                qw_next = res[2];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_valid[NDIV];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            qx_reg     <= qx_next;
            qy_reg     <= qy_next;
            qz_reg     <= qz_next;
            qw_reg     <= qw_next;
            branch_reg <= fin.branch;
            bad_reg    <= fin.bad;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_quat_x       = qx_reg;
    assign m_quat_y       = qy_reg;
    assign m_quat_z       = qz_reg;
    assign m_quat_w       = qw_reg;
    assign m_branch_taken = branch_reg;
    assign m_bad_input    = bad_reg;

endmodule

@@ design/r2q_front.sv @@
module r2q_front #(
    parameter int FRAC_BITS = 14
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [r2q_pkg::ELEM_W-1:0] e0,
    input  logic signed [r2q_pkg::ELEM_W-1:0] e1,
    input  logic signed [r2q_pkg::ELEM_W-1:0] e2,
    input  logic signed [r2q_pkg::ELEM_W-1:0] e4,
    input  logic signed [r2q_pkg::ELEM_W-1:0] e5,
    input  logic signed [r2q_pkg::ELEM_W-1:0] e6,
    input  logic signed [r2q_pkg::ELEM_W-1:0] e8,
    input  logic signed [r2q_pkg::ELEM_W-1:0] e9,
    input  logic signed [r2q_pkg::ELEM_W-1:0] e10,
    output logic                              valid_reg,
    output logic [r2q_pkg::R_W-1:0]           r_reg,
    output r2q_pkg::sq_side_t                 side_reg
);
    import r2q_pkg::*;

    localparam int W = 20;

    logic signed [W-1:0] one;
    logic signed [W-1:0] x0, x1, x2, x4, x5, x6, x8, x9, x10;
    logic signed [W-1:0] t;
    logic signed [W-1:0] r;
    logic [R_W-1:0]      r_next;
    sq_side_t            side_next;

    always_comb begin
        one = W'(1) <<< FRAC_BITS;
        x0  = W'(e0);
        x1  = W'(e1);
        x2  = W'(e2);
        x4  = W'(e4);
        x5  = W'(e5);
        x6  = W'(e6);
        x8  = W'(e8);
        x9  = W'(e9);
        x10 = W'(e10);
        t   = x0 + x5 + x10;
        side_next.bad = 1'b0;
        if (t > 0) begin
            side_next.branch = BR_TRACE;
            r                = one + t;
            side_next.oa     = OP_W'(x9 - x6);
            side_next.ob     = OP_W'(x2 - x8);
            side_next.oc     = OP_W'(x4 - x1);
        end else if (x0 > x5 && x0 > x10) begin
            side_next.branch = BR_X;
            r                = one + x0 - x5 - x10;
            side_next.oa     = OP_W'(x1 + x4);
            side_next.ob     = OP_W'(x8 + x2);
            side_next.oc     = OP_W'(x9 - x6);
        end else if (x5 > x10) begin
            side_next.branch = BR_Y;
            r                = one + x5 - x0 - x10;
            side_next.oa     = OP_W'(x1 + x4);
            side_next.ob     = OP_W'(x6 + x9);
            side_next.oc     = OP_W'(x2 - x8);
        end else begin
            side_next.branch = BR_Z;
            r                = one + x10 - x0 - x5;
            side_next.oa     = OP_W'(x2 + x8);
            side_next.ob     = OP_W'(x6 + x9);
            side_next.oc     = OP_W'(x4 - x1);
        end
        // A radicand that is not positive is clamped to one LSB and flagged.
        if (r <= 0) begin
            r_next        = R_W'(1);
            side_next.bad = 1'b1;
        end else begin
            r_next = R_W'(r);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg    <= r_next;
            side_reg <= side_next;
        end
    end

endmodule

@@ design/r2q_sqrt_cell.sv @@
module r2q_sqrt_cell #(
    parameter int QW = 17
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                valid_in,
    input  logic [QW+1:0]       rem_in,
    input  logic [QW-1:0]       root_in,
    input  logic [2*QW-1:0]     val_in,
    input  r2q_pkg::sq_side_t   side_in,
    output logic                valid_reg,
    output logic [QW+1:0]       rem_reg,
    output logic [QW-1:0]       root_reg,
    output logic [2*QW-1:0]     val_reg,
    output r2q_pkg::sq_side_t   side_reg
);
    import r2q_pkg::*;

    logic [QW+1:0] rem_sh;
    logic [QW+1:0] trial;
    logic          take;
    logic [QW+1:0] rem_next;
    logic [QW-1:0] root_next;

    // One root bit per cell: bring down the next two radicand bits and try
    // the candidate 4*root + 1.
    always_comb begin
        rem_sh    = {rem_in[QW-1:0], val_in[2*QW-1 -: 2]};
        trial     = {root_in, 2'b01};
        take      = rem_sh >= trial;
        rem_next  = take ? rem_sh - trial : rem_sh;
        root_next = {root_in[QW-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            val_reg  <= {val_in[2*QW-3:0], 2'b00};
            side_reg <= side_in;
        end
    end

endmodule

@@ design/r2q_div_cell.sv @@
module r2q_div_cell #(
    parameter int NW  = 35,
    parameter int BIT = 15
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         en,
    input  logic                                         valid_in,
    input  logic [r2q_pkg::LANES-1:0][NW-1:0]            rem_in,
    input  logic [r2q_pkg::LANES-1:0][r2q_pkg::QUAT_W-1:0] q_in,
    input  logic [NW-1:0]                                dvs_in,
    input  r2q_pkg::dv_side_t                            side_in,
    output logic                                         valid_reg,
    output logic [r2q_pkg::LANES-1:0][NW-1:0]            rem_reg,
    output logic [r2q_pkg::LANES-1:0][r2q_pkg::QUAT_W-1:0] q_reg,
    output logic [NW-1:0]                                dvs_reg,
    output r2q_pkg::dv_side_t                            side_reg
);
    import r2q_pkg::*;

    logic [NW-1:0]                   sub;
    logic [LANES-1:0]                ge;
    logic [LANES-1:0][NW-1:0]        rem_next;
    logic [LANES-1:0][QUAT_W-1:0]    q_next;

    // Restoring division, one quotient bit per cell for all three lanes.
    always_comb begin
        sub = dvs_in << BIT;
        for (int l = 0; l < LANES; l++) begin
            ge[l]       = rem_in[l] >= sub;
            rem_next[l] = ge[l] ? rem_in[l] - sub : rem_in[l];
            q_next[l]   = {q_in[l][QUAT_W-2:0], ge[l]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            dvs_reg  <= dvs_in;
            side_reg <= side_in;
        end
    end

endmodule

@@ design/r2q_checker.sv @@
module r2q_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [r2q_pkg::QUAT_W-1:0] m_quat_x,
    input logic signed [r2q_pkg::QUAT_W-1:0] m_quat_y,
    input logic signed [r2q_pkg::QUAT_W-1:0] m_quat_z,
    input logic signed [r2q_pkg::QUAT_W-1:0] m_quat_w,
    input logic [1:0]                        m_branch_taken,
    input logic                              m_bad_input
);
    import r2q_pkg::*;

    // A stalled item stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_quat_x) && $stable(m_quat_y)
            && $stable(m_quat_z) && $stable(m_quat_w) && $stable(m_branch_taken))
        else $error("result item changed while stalled");

    // The component chosen as largest is a square root and never negative.
    a_big_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_branch_taken == BR_TRACE && m_quat_w >= 0)
            || (m_branch_taken == BR_X && m_quat_x >= 0)
            || (m_branch_taken == BR_Y && m_quat_y >= 0)
            || (m_branch_taken == BR_Z && m_quat_z >= 0))
        else $error("largest component negative");

    // A positive trace always gives a positive radicand.
    a_trace_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_branch_taken == BR_TRACE |-> !m_bad_input)
        else $error("clamp flagged on trace branch");

    // The pipeline comes out of reset empty.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind rotation_matrix_to_quaternion_unit r2q_checker u_r2q_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_quat_x       (m_quat_x),
    .m_quat_y       (m_quat_y),
    .m_quat_z       (m_quat_z),
    .m_quat_w       (m_quat_w),
    .m_branch_taken (m_branch_taken),
    .m_bad_input    (m_bad_input)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import r2q_pkg::*;

    localparam int FRAC = 14;
    localparam int LATENCY = (FRAC + 20) / 2 + 19;
    localparam int N_RANDOM = 1800;
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic signed [ELEM_W-1:0] elem_t;

    typedef struct {
        elem_t e0, e1, e2, e4, e5, e6, e8, e9, e10;
    } matrix_t;

    typedef struct {
        logic signed [QUAT_W-1:0] qx, qy, qz, qw;
        branch_t                  branch;
        logic                     bad;
    } quat_res_t;

    // Directed row: the expected result is typed in only where has_exp is set.
    typedef struct {
        matrix_t   m;
        bit        has_exp;
        quat_res_t q;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    elem_t s_elem_0 = '0, s_elem_1 = '0, s_elem_2 = '0, s_elem_4 = '0, s_elem_5 = '0;
    elem_t s_elem_6 = '0, s_elem_8 = '0, s_elem_9 = '0, s_elem_10 = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [QUAT_W-1:0] m_quat_x, m_quat_y, m_quat_z, m_quat_w;
    logic [1:0] m_branch_taken;
    logic m_bad_input;

    rotation_matrix_to_quaternion_unit #(.FRAC_BITS(FRAC)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_elem_0(s_elem_0), .s_elem_1(s_elem_1), .s_elem_2(s_elem_2),
        .s_elem_4(s_elem_4), .s_elem_5(s_elem_5), .s_elem_6(s_elem_6),
        .s_elem_8(s_elem_8), .s_elem_9(s_elem_9), .s_elem_10(s_elem_10),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_quat_x(m_quat_x), .m_quat_y(m_quat_y), .m_quat_z(m_quat_z),
        .m_quat_w(m_quat_w), .m_branch_taken(m_branch_taken), .m_bad_input(m_bad_input)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    quat_res_t pending_quats[$];
    int  errors = 0;
    longint cycle = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;

    function automatic longint int_sqrt(longint v);
        longint res, b;
        res = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >>> 1) + b;
            end else begin
                res = res >>> 1;
            end
            b = b >>> 2;
        end
        return res;
    endfunction

    function automatic logic signed [QUAT_W-1:0] clip16(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[QUAT_W-1:0];
    endfunction

    // Rounded half away from zero.
    function automatic logic signed [QUAT_W-1:0] round_div(longint op, longint d);
        longint mag, q;
        mag = (op < 0) ? -op : op;
        q = ((mag <<< (FRAC + 1)) + d) / (2 * d);
        return clip16((op < 0) ? -q : q);
    endfunction

    function automatic quat_res_t predict_quat(matrix_t m);
        quat_res_t q;
        longint e0, e1, e2, e4, e5, e6, e8, e9, e10, t, r, oa, ob, oc, d;
        logic signed [QUAT_W-1:0] big, ra, rb, rc;
        e0 = m.e0; e1 = m.e1; e2 = m.e2; e4 = m.e4; e5 = m.e5;
        e6 = m.e6; e8 = m.e8; e9 = m.e9; e10 = m.e10;
        t = e0 + e5 + e10;
        q.bad = 1'b0;
        if (t > 0) begin
            q.branch = BR_TRACE; r = (1 <<< FRAC) + t;
            oa = e9 - e6; ob = e2 - e8; oc = e4 - e1;
        end else if (e0 > e5 && e0 > e10) begin
            q.branch = BR_X; r = (1 <<< FRAC) + e0 - e5 - e10;
            oa = e1 + e4; ob = e8 + e2; oc = e9 - e6;
        end else if (e5 > e10) begin
            q.branch = BR_Y; r = (1 <<< FRAC) + e5 - e0 - e10;
            oa = e1 + e4; ob = e6 + e9; oc = e2 - e8;
        end else begin
            q.branch = BR_Z; r = (1 <<< FRAC) + e10 - e0 - e5;
            oa = e2 + e8; ob = e6 + e9; oc = e4 - e1;
        end
        if (r <= 0) begin
            r = 1;
            q.bad = 1'b1;
        end
        big = clip16(int_sqrt(r <<< (FRAC - 2)));
        d = int_sqrt(r <<< (FRAC + 2));
        ra = round_div(oa, d);
        rb = round_div(ob, d);
        rc = round_div(oc, d);
        case (q.branch)
            BR_TRACE: begin q.qx = ra; q.qy = rb; q.qz = rc; q.qw = big; end
            BR_X:     begin q.qx = big; q.qy = ra; q.qz = rb; q.qw = rc; end
            BR_Y:     begin q.qx = ra; q.qy = big; q.qz = rb; q.qw = rc; end
            default:  begin q.qx = ra; q.qy = rb; q.qz = big; q.qw = rc; end
        endcase
        return q;
    endfunction

    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random stall, compare each accepted item with the oldest expectation.
    always @(posedge aclk) begin
        quat_res_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_quats.size() == 0) begin
                    $error("result item with no expectation waiting");
                    errors++;
                end else begin
                    e = pending_quats.pop_front();
                    if (m_quat_x !== e.qx) begin
                        $error("quat_x expected %0d got %0d", e.qx, m_quat_x); errors++;
                    end
                    if (m_quat_y !== e.qy) begin
                        $error("quat_y expected %0d got %0d", e.qy, m_quat_y); errors++;
                    end
                    if (m_quat_z !== e.qz) begin
                        $error("quat_z expected %0d got %0d", e.qz, m_quat_z); errors++;
                    end
                    if (m_quat_w !== e.qw) begin
                        $error("quat_w expected %0d got %0d", e.qw, m_quat_w); errors++;
                    end
                    if (m_branch_taken !== e.branch) begin
                        $error("branch_taken expected %0d got %0d", e.branch, m_branch_taken);
                        errors++;
                    end
                    if (m_bad_input !== e.bad) begin
                        $error("bad_input expected %0d got %0d", e.bad, m_bad_input);
                        errors++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Holds valid and payload until the item is accepted; valid only drops
    // when the sender idles, so back-to-back items keep it high.
    task automatic send_matrix(matrix_t m, bit has_exp, quat_res_t q);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_elem_0 <= m.e0; s_elem_1 <= m.e1; s_elem_2 <= m.e2;
        s_elem_4 <= m.e4; s_elem_5 <= m.e5; s_elem_6 <= m.e6;
        s_elem_8 <= m.e8; s_elem_9 <= m.e9; s_elem_10 <= m.e10;
        do @(posedge aclk); while (!s_ready);
        pending_quats.push_back(has_exp ? q : predict_quat(m));
    endtask

    function automatic matrix_t uniform_matrix(elem_t v);
        matrix_t m;
        m.e0 = v; m.e1 = v; m.e2 = v; m.e4 = v; m.e5 = v;
        m.e6 = v; m.e8 = v; m.e9 = v; m.e10 = v;
        return m;
    endfunction

    function automatic elem_t rand_elem();
        case ($urandom_range(3))
            0: return elem_t'($urandom);
            1: return elem_t'($urandom_range(32767));
            2: return elem_t'(-$signed({1'b0, 15'($urandom)}));
            default: return elem_t'($urandom_range(2 * 16384) - 16384);
        endcase
    endfunction

    // A random matrix: usually all elements in range, sometimes with one branch favoured.
    function automatic matrix_t random_matrix();
        matrix_t m;
        m.e0 = rand_elem(); m.e1 = rand_elem(); m.e2 = rand_elem();
        m.e4 = rand_elem(); m.e5 = rand_elem(); m.e6 = rand_elem();
        m.e8 = rand_elem(); m.e9 = rand_elem(); m.e10 = rand_elem();
        if ($urandom_range(3) != 0) begin
            m.e0 = elem_t'($urandom_range(32768) - 16384);
            m.e5 = elem_t'($urandom_range(32768) - 16384);
            m.e10 = elem_t'($urandom_range(32768) - 16384);
            m.e1 = elem_t'($urandom_range(32768) - 16384);
            m.e2 = elem_t'($urandom_range(32768) - 16384);
            m.e4 = elem_t'($urandom_range(32768) - 16384);
            m.e6 = elem_t'($urandom_range(32768) - 16384);
            m.e8 = elem_t'($urandom_range(32768) - 16384);
            m.e9 = elem_t'($urandom_range(32768) - 16384);
            if ($urandom_range(1)) begin
                case ($urandom_range(2))
                    0: m.e0 = elem_t'($urandom_range(16384));
                    1: m.e5 = elem_t'($urandom_range(16384));
                    default: m.e10 = elem_t'($urandom_range(16384));
                endcase
            end
        end
        if ($urandom_range(15) == 0) begin
            // Equal diagonals test the strict tie rules.
            m.e5 = m.e0;
            if ($urandom_range(1)) m.e10 = m.e0;
        end
        return m;
    endfunction

    row_t rows[$];

    task automatic add_row(matrix_t m, bit has_exp, quat_res_t q);
        row_t r;
        r.m = m; r.has_exp = has_exp; r.q = q;
        rows.push_back(r);
    endtask

    initial begin
        matrix_t m;
        quat_res_t q, none;
        int phase, k;
        none = '{default: 0, branch: BR_TRACE};

        // Zero matrix: the trace is not positive and the diagonal ties fall
        // through to the z branch, r = 1.0, z = 0.5 exactly.
        q = '{qx: 0, qy: 0, qz: 16'sd8192, qw: 0, branch: BR_Z, bad: 1'b0};
        add_row(uniform_matrix(0), 1, q);
        // Identity.
        m = uniform_matrix(0); m.e0 = 16384; m.e5 = 16384; m.e10 = 16384;
        q = '{qx: 0, qy: 0, qz: 0, qw: 16'sd16384, branch: BR_TRACE, bad: 1'b0};
        add_row(m, 1, q);
        // All most negative: z branch (ties), radicand 16384 + 32768 > 0.
        add_row(uniform_matrix(-32768), 0, none);
        add_row(uniform_matrix(32767), 0, none);
        // Rotations by pi about x, y and z.
        m = uniform_matrix(0); m.e0 = 16384; m.e5 = -16384; m.e10 = -16384;
        add_row(m, 0, none);
        m = uniform_matrix(0); m.e0 = -16384; m.e5 = 16384; m.e10 = -16384;
        add_row(m, 0, none);
        m = uniform_matrix(0); m.e0 = -16384; m.e5 = -16384; m.e10 = 16384;
        add_row(m, 0, none);
        // Extreme diagonals: the chosen branch still gives a positive radicand.
        m = uniform_matrix(0); m.e0 = -32768; m.e5 = -32768; m.e10 = -32768;
        m.e1 = 32767; m.e4 = 32767; m.e2 = -32768; m.e8 = -32768;
        add_row(m, 0, none);
        m = uniform_matrix(32767); m.e0 = -32768; m.e5 = 32767; m.e10 = -32768;
        add_row(m, 0, none);
        m = uniform_matrix(-32768); m.e0 = 0; m.e5 = -32768; m.e10 = 16384;
        add_row(m, 0, none);
        // Trace exactly zero and diagonal ties.
        m = uniform_matrix(1000); m.e0 = 0; m.e5 = 0; m.e10 = 0;
        add_row(m, 0, none);
        m = uniform_matrix(-5); m.e0 = 100; m.e5 = 100; m.e10 = -200;
        add_row(m, 0, none);
        m = uniform_matrix(7); m.e0 = -100; m.e5 = 50; m.e10 = 50;
        add_row(m, 0, none);
        // Off-diagonals at the extremes of their range.
        m = uniform_matrix(0); m.e0 = -16384; m.e5 = -16384; m.e10 = 32767;
        m.e2 = 32767; m.e8 = 32767; m.e6 = -32768; m.e9 = -32768;
        add_row(m, 0, none);
        m = uniform_matrix(0); m.e0 = 1; m.e9 = 32767; m.e6 = -32768; m.e4 = -32768;
        add_row(m, 0, none);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        m_ready <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) send_matrix(rows[i].m, rows[i].has_exp, rows[i].q);

        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                1: begin send_idle_pct = 54; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 54; end
                3: begin send_idle_pct = 15; recv_stall_pct = 15; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (k = 0; k < N_RANDOM / 5; k++) send_matrix(random_matrix(), 0, none);
        end
        s_valid <= 1'b0;

        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (pending_quats.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (errors == 0 && pending_quats.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/r2q_pkg.sv
design/r2q_front.sv
design/r2q_sqrt_cell.sv
design/r2q_div_cell.sv
design/rotation_matrix_to_quaternion_unit.sv
design/r2q_checker.sv
tb/tb_top.sv
